/* hdl/tfr_pkg.sv */
// Shared types and constants for the truncated float rebuild block.
package tfr_pkg;

  localparam int unsigned MANT_W = 32;
  localparam int unsigned EXP_W  = 8;
  localparam int unsigned MB_W   = 6;

  // Register indexes on the configuration channel
  localparam logic [7:0] CFG_IDX_MANT_BITS   = 8'd0;
  localparam logic [7:0] CFG_IDX_SIGNED_MODE = 8'd1;

  localparam logic [MB_W-1:0] MANT_BITS_RST = 6'd32;

  localparam logic [31:0] POS_INF    = 32'h7F80_0000;
  localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
  localparam int          MIN_NORM_E = -126;

  typedef struct packed {
    logic [MB_W-1:0] mant_bits;
    logic            signed_mode;
  } cfg_t;

endpackage

/* hdl/tfr_convert.sv */
// Combinational conversion of one mantissa/exponent pair to a single-precision pattern.
module tfr_convert (
  input  tfr_pkg::cfg_t                 cfg_i,
  input  logic [tfr_pkg::MANT_W-1:0]    mantissa_i,
  input  logic [tfr_pkg::EXP_W-1:0]     exponent_i,
  output logic [31:0]                   result_bits_o
);

  logic [4:0]        lead;
  logic [31:0]       norm;
  logic signed [9:0] scale;
  logic signed [9:0] top_e;
  logic signed [9:0] under;
  logic [9:0]        amt_full;
  logic [5:0]        amt;
  logic              subnorm;
  logic [63:0]       shifted;
  logic [31:0]       sig;
  logic              round_up;
  logic [32:0]       sig_r;
  logic [8:0]        exp_fld;
  logic [33:0]       packed_sum;
  logic [31:0]       mag;
  logic [5:0]        mb_m1;
  logic              neg;

  // Find the leading one
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mantissa_i[i]) lead = 5'(i);
    end
  end

  assign norm  = mantissa_i << (5'd31 - lead);
  assign scale = 10'(signed'(exponent_i)) - signed'({4'b0, cfg_i.mant_bits})
               + signed'({9'b0, cfg_i.signed_mode});
  assign top_e = scale + signed'({5'b0, lead});

  assign subnorm  = top_e < 10'(tfr_pkg::MIN_NORM_E);
  assign under    = 10'(tfr_pkg::MIN_NORM_E) - top_e;
  assign amt_full = subnorm ? (10'd8 + 10'(under)) : 10'd8;
  assign amt      = (amt_full > 10'd63) ? 6'd63 : amt_full[5:0];

  assign shifted  = {norm, 32'b0} >> amt;
  assign sig      = shifted[63:32];
  assign round_up = shifted[31] && ((|shifted[30:0]) || sig[0]);
  assign sig_r    = {1'b0, sig} + {32'b0, round_up};

  assign exp_fld    = subnorm ? 9'd0 : 9'(top_e + 10'sd126);
  assign packed_sum = {2'b0, exp_fld, 23'b0} + {1'b0, sig_r};

  always_comb begin
    if (mantissa_i == '0) begin
      mag = '0;
    end else if (packed_sum >= {2'b0, tfr_pkg::POS_INF}) begin
      mag = tfr_pkg::POS_INF;
    end else begin
      mag = packed_sum[31:0];
    end
  end

  // Sign test: any bit at or above mant_bits-1
  assign mb_m1 = cfg_i.mant_bits - 6'd1;
  always_comb begin
    if (!cfg_i.signed_mode) begin
      neg = 1'b0;
    end else if (cfg_i.mant_bits == '0) begin
      neg = mantissa_i != '0;
    end else if (cfg_i.mant_bits > 6'd32) begin
      neg = 1'b0;
    end else begin
      neg = (mantissa_i >> mb_m1) != '0;
    end
  end

  assign result_bits_o = neg ? (mag | tfr_pkg::SIGN_MASK) : mag;

endmodule

/* hdl/truncated_float_reconstruct_core.sv */
// Top level of the truncated float rebuild block: registers, config and result strobe.
//
// Each transfer taken on start_i yields one single-precision pattern on
// result_bits_o, marked by result_valid_o for exactly one cycle, after the
// start transfer passes through the input register and then the result
// register. busy_o stays low, so a new item may start every cycle;
// the rate is one item per cycle, set by the single conversion stage (leading
// one search, 64-bit right shift, round and pack). The receiver cannot stall,
// so every result must be taken in its strobe cycle. Write mant_bits (index 0)
// and signed_mode (index 1) only while no item is in flight; other indexes
// are accepted and dropped.
module truncated_float_reconstruct_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] mantissa_i,
  input  logic [7:0]  exponent_i,
  output logic        result_valid_o,
  output logic [31:0] result_bits_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  tfr_pkg::cfg_t cfg_q;
  logic          in_vld_q;
  logic [31:0]   mant_q;
  logic [7:0]    exp_q;
  logic          res_vld_q;
  logic [31:0]   res_q;
  logic [31:0]   res_d;
  logic          take;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign take        = start_i && !busy_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mant_bits   <= tfr_pkg::MANT_BITS_RST;
      cfg_q.signed_mode <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tfr_pkg::CFG_IDX_MANT_BITS) begin
        cfg_q.mant_bits <= cfg_data_i[5:0];
      end else if (cfg_index_i == tfr_pkg::CFG_IDX_SIGNED_MODE) begin
        cfg_q.signed_mode <= cfg_data_i[0];
      end
    end
  end

  // Input register: capture each start transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mant_q <= mantissa_i;
      exp_q  <= exponent_i;
    end
  end

  tfr_convert u_convert (
    .cfg_i         (cfg_q),
    .mantissa_i    (mant_q),
    .exponent_i    (exp_q),
    .result_bits_o (res_d)
  );

  // Result register: advance the strobe, hold data for its one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_bits_o  = res_q;

  // Every strobe comes from a start that passed the input and result registers
  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##2 (result_valid_o == $past(take, 2)))
    else $error("result strobe does not match start two cycles earlier");

  // Zero mantissa always rebuilds to +0
  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && mant_q == '0) |=> (result_bits_o == '0))
    else $error("zero mantissa did not give +0");

  // Never emit a NaN pattern
  a_no_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_bits_o[30:23] != 8'hFF || result_bits_o[22:0] == '0))
    else $error("NaN pattern on result");

  // Unsigned mode never sets the sign
  a_unsigned_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !cfg_q.signed_mode) |=> !result_bits_o[31])
    else $error("sign set in unsigned mode");

endmodule
